// ===== sv/mcmd_pkg.sv =====
`default_nettype none

package mcmd_pkg;

   localparam logic [1:0] CMD_DECODE = 2'd0;
   localparam logic [1:0] CMD_FRAME  = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [3:0] KIND_NONE    = 4'd0;
   localparam logic [3:0] KIND_ON      = 4'd1;
   localparam logic [3:0] KIND_OFF     = 4'd2;
   localparam logic [3:0] KIND_CC      = 4'd3;
   localparam logic [3:0] KIND_PROGRAM = 4'd4;
   localparam logic [3:0] KIND_BEND    = 4'd5;
   localparam logic [3:0] KIND_TOUCH   = 4'd6;
   localparam logic [3:0] KIND_POLY    = 4'd7;
   localparam logic [3:0] KIND_CLOCK   = 4'd8;
   localparam logic [3:0] KIND_START   = 4'd9;
   localparam logic [3:0] KIND_CONT    = 4'd10;
   localparam logic [3:0] KIND_STOP    = 4'd11;

   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_POLY     = 4'hA;
   localparam logic [3:0] TYPE_CC       = 4'hB;
   localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
   localparam logic [3:0] TYPE_TOUCH    = 4'hD;
   localparam logic [3:0] TYPE_BEND     = 4'hE;

   localparam logic [7:0] SYS_CLOCK = 8'hF8;
   localparam logic [7:0] SYS_START = 8'hFA;
   localparam logic [7:0] SYS_CONT  = 8'hFB;
   localparam logic [7:0] SYS_STOP  = 8'hFC;

   localparam logic [13:0] BEND_CENTER = 14'd8192;

   localparam int FLAG_ON   = 0;
   localparam int FLAG_OFF  = 1;
   localparam int FLAG_CC   = 2;
   localparam int FLAG_BEND = 3;

   typedef struct packed {
      logic [3:0]  kind;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [6:0]  value;
      logic [13:0] bend;
      logic [3:0]  set_flags;
      logic        note_on_wr;
      logic        cc_wr;
      logic        bend_wr;
   } event_type;

endpackage

`default_nettype wire

// ===== sv/mcmd_decode.sv =====
`default_nettype none

module mcmd_decode (
   input  wire logic [4:0]         channel_filter,
   input  wire logic [7:0]         status_byte,
   input  wire logic [6:0]         first_data,
   input  wire logic [6:0]         second_data,
   input  wire logic [1:0]         message_length,
   output mcmd_pkg::event_type     ev
);

   logic [3:0] chan;
   logic [3:0] ty;
   logic       pass;
   logic       len3;
   logic       len2;

   always_comb begin
      chan = status_byte[3:0];
      ty   = status_byte[7:4];
      len3 = (message_length == 2'd3);
      len2 = (message_length >= 2'd2);
      pass = (message_length != 2'd0) &&
             ((channel_filter == 5'd0) || ({1'b0, chan} == channel_filter - 5'd1));

      ev = '0;
      if (pass) begin
         case (ty)
            mcmd_pkg::TYPE_NOTE_ON: begin
               if (len3) begin
                  ev.note  = first_data;
                  ev.value = second_data;
                  if (second_data != 7'd0) begin
                     ev.kind = mcmd_pkg::KIND_ON;
                     ev.set_flags[mcmd_pkg::FLAG_ON] = 1'b1;
                     ev.note_on_wr = 1'b1;
                  end else begin
                     ev.kind = mcmd_pkg::KIND_OFF;
                     ev.set_flags[mcmd_pkg::FLAG_OFF] = 1'b1;
                  end
               end
            end
            mcmd_pkg::TYPE_NOTE_OFF: begin
               if (len3) begin
                  ev.kind  = mcmd_pkg::KIND_OFF;
                  ev.note  = first_data;
                  ev.value = second_data;
                  ev.set_flags[mcmd_pkg::FLAG_OFF] = 1'b1;
               end
            end
            mcmd_pkg::TYPE_CC: begin
               if (len3) begin
                  ev.kind  = mcmd_pkg::KIND_CC;
                  ev.note  = first_data;
                  ev.value = second_data;
                  ev.set_flags[mcmd_pkg::FLAG_CC] = 1'b1;
                  ev.cc_wr = 1'b1;
               end
            end
            mcmd_pkg::TYPE_PROGRAM: begin
               if (len2) begin
                  ev.kind  = mcmd_pkg::KIND_PROGRAM;
                  ev.value = first_data;
               end
            end
            mcmd_pkg::TYPE_BEND: begin
               if (len3) begin
                  ev.kind    = mcmd_pkg::KIND_BEND;
                  ev.bend    = {second_data, first_data} - mcmd_pkg::BEND_CENTER;
                  ev.bend_wr = 1'b1;
                  ev.set_flags[mcmd_pkg::FLAG_BEND] = 1'b1;
               end
            end
            mcmd_pkg::TYPE_TOUCH: begin
               if (len2) begin
                  ev.kind  = mcmd_pkg::KIND_TOUCH;
                  ev.value = first_data;
               end
            end
            mcmd_pkg::TYPE_POLY: begin
               if (len3) begin
                  ev.kind  = mcmd_pkg::KIND_POLY;
                  ev.note  = first_data;
                  ev.value = second_data;
               end
            end
            default: begin
               case (status_byte)
                  mcmd_pkg::SYS_CLOCK: ev.kind = mcmd_pkg::KIND_CLOCK;
                  mcmd_pkg::SYS_START: ev.kind = mcmd_pkg::KIND_START;
                  mcmd_pkg::SYS_CONT:  ev.kind = mcmd_pkg::KIND_CONT;
                  mcmd_pkg::SYS_STOP:  ev.kind = mcmd_pkg::KIND_STOP;
                  default:             ev.kind = mcmd_pkg::KIND_NONE;
               endcase
            end
         endcase
         if (ev.kind != mcmd_pkg::KIND_NONE) begin
            ev.channel = chan;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/midi_channel_message_decoder.sv =====
// channel | handshake          | payload
// req     | req_valid/req_stall| command, status, two data bytes, length, query number
// rsp     | rsp_valid/rsp_stall| event fields, query fields, frame flags, held values
// csr     | csr_valid/csr_ready| 5-bit channel filter, always ready
//
// one transaction per cycle while req_stall is low; a result leaves through stage 1
// (controller value memory read), then the output register
// synchronous reset clears flags, held values and the controller valid bits at
// once; no clearing pass, a transaction may follow reset immediately
// rsp_stall backs up into req_stall only when both internal stages are full
`default_nettype none

module midi_channel_message_decoder (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_command,
   input  wire logic [7:0]         req_status_byte,
   input  wire logic [6:0]         req_first_data,
   input  wire logic [6:0]         req_second_data,
   input  wire logic [1:0]         req_message_length,
   input  wire logic [6:0]         req_query_number,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_event_kind,
   output logic [3:0]              rsp_event_channel,
   output logic [6:0]              rsp_event_note,
   output logic [6:0]              rsp_event_value,
   output logic signed [13:0]      rsp_event_bend,
   output logic                    rsp_note_seen,
   output logic                    rsp_control_seen,
   output logic [6:0]              rsp_control_level,
   output logic [3:0]              rsp_frame_flags,
   output logic [6:0]              rsp_recent_note,
   output logic [6:0]              rsp_recent_velocity,
   output logic signed [13:0]      rsp_bend_level,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [4:0]         csr_data
);

   logic [4:0]   filter_ff;

   logic [127:0] note_flags_ff, note_flags_in;
   logic [127:0] cc_flags_ff, cc_flags_in;
   logic [127:0] cv_valid_ff, cv_valid_in;
   logic [6:0]   cv_mem [128];
   logic [6:0]   cv_rd_ff;

   logic [3:0]   seen_ff, seen_in;
   logic [6:0]   last_note_ff, last_note_in;
   logic [6:0]   last_vel_ff, last_vel_in;
   logic [13:0]  bend_ff, bend_in;

   mcmd_pkg::event_type dec_ev;
   mcmd_pkg::event_type ev;

   logic         accept;
   logic         is_decode;
   logic         is_frame;
   logic         is_query;

   // stage 1
   logic         s1_valid_ff, s1_valid_in;
   logic         s1_move;
   mcmd_pkg::event_type s1_ev_ff;
   logic         s1_query_ff;
   logic         s1_note_seen_ff;
   logic         s1_cc_seen_ff;
   logic         s1_cv_valid_ff;
   logic [3:0]   s1_seen_ff;
   logic [6:0]   s1_note_ff;
   logic [6:0]   s1_vel_ff;
   logic [13:0]  s1_bend_ff;

   // output register
   logic         out_valid_ff, out_valid_in;
   logic [3:0]   out_kind_ff;
   logic [3:0]   out_chan_ff;
   logic [6:0]   out_note_ff;
   logic [6:0]   out_value_ff;
   logic [13:0]  out_ev_bend_ff;
   logic         out_nseen_ff;
   logic         out_cseen_ff;
   logic [6:0]   out_level_ff;
   logic [3:0]   out_flags_ff;
   logic [6:0]   out_rnote_ff;
   logic [6:0]   out_rvel_ff;
   logic [13:0]  out_bend_ff;

   mcmd_decode u_decode (
      .channel_filter (filter_ff),
      .status_byte    (req_status_byte),
      .first_data     (req_first_data),
      .second_data    (req_second_data),
      .message_length (req_message_length),
      .ev             (dec_ev)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      s1_move     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall   = s1_valid_ff && out_valid_ff && rsp_stall;
      accept      = req_valid && !req_stall;
      is_decode   = (req_command == mcmd_pkg::CMD_DECODE);
      is_frame    = (req_command == mcmd_pkg::CMD_FRAME);
      is_query    = (req_command == mcmd_pkg::CMD_QUERY);
      ev          = is_decode ? dec_ev : '0;
      s1_valid_in = accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_comb begin
      note_flags_in = note_flags_ff;
      cc_flags_in   = cc_flags_ff;
      cv_valid_in   = cv_valid_ff;
      seen_in       = seen_ff | ev.set_flags;
      last_note_in  = last_note_ff;
      last_vel_in   = last_vel_ff;
      bend_in       = bend_ff;
      if (is_frame) begin
         note_flags_in = '0;
         cc_flags_in   = '0;
         seen_in       = '0;
      end
      if (ev.note_on_wr) begin
         note_flags_in[req_first_data] = 1'b1;
         last_note_in = req_first_data;
         last_vel_in  = req_second_data;
      end
      if (ev.cc_wr) begin
         cc_flags_in[req_first_data] = 1'b1;
         cv_valid_in[req_first_data] = 1'b1;
      end
      if (ev.bend_wr) begin
         bend_in = ev.bend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff     <= '0;
         note_flags_ff <= '0;
         cc_flags_ff   <= '0;
         cv_valid_ff   <= '0;
         seen_ff       <= '0;
         last_note_ff  <= '0;
         last_vel_ff   <= '0;
         bend_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            filter_ff <= csr_data;
         end
         if (accept) begin
            note_flags_ff <= note_flags_in;
            cc_flags_ff   <= cc_flags_in;
            cv_valid_ff   <= cv_valid_in;
            seen_ff       <= seen_in;
            last_note_ff  <= last_note_in;
            last_vel_ff   <= last_vel_in;
            bend_ff       <= bend_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && ev.cc_wr) begin
         cv_mem[req_first_data] <= req_second_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cv_rd_ff <= cv_mem[req_query_number];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ev_ff        <= ev;
         s1_query_ff     <= is_query;
         s1_note_seen_ff <= is_query && note_flags_ff[req_query_number];
         s1_cc_seen_ff   <= is_query && cc_flags_ff[req_query_number];
         s1_cv_valid_ff  <= cv_valid_ff[req_query_number];
         s1_seen_ff      <= seen_in;
         s1_note_ff      <= last_note_in;
         s1_vel_ff       <= last_vel_in;
         s1_bend_ff      <= bend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_kind_ff    <= s1_ev_ff.kind;
         out_chan_ff    <= s1_ev_ff.channel;
         out_note_ff    <= s1_ev_ff.note;
         out_value_ff   <= s1_ev_ff.value;
         out_ev_bend_ff <= s1_ev_ff.bend;
         out_nseen_ff   <= s1_note_seen_ff;
         out_cseen_ff   <= s1_cc_seen_ff;
         out_level_ff   <= (s1_query_ff && s1_cv_valid_ff) ? cv_rd_ff : 7'd0;
         out_flags_ff   <= s1_seen_ff;
         out_rnote_ff   <= s1_note_ff;
         out_rvel_ff    <= s1_vel_ff;
         out_bend_ff    <= s1_bend_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_kind      = out_kind_ff;
   assign rsp_event_channel   = out_chan_ff;
   assign rsp_event_note      = out_note_ff;
   assign rsp_event_value     = out_value_ff;
   assign rsp_event_bend      = $signed(out_ev_bend_ff);
   assign rsp_note_seen       = out_nseen_ff;
   assign rsp_control_seen    = out_cseen_ff;
   assign rsp_control_level   = out_level_ff;
   assign rsp_frame_flags     = out_flags_ff;
   assign rsp_recent_note     = out_rnote_ff;
   assign rsp_recent_velocity = out_rvel_ff;
   assign rsp_bend_level      = $signed(out_bend_ff);

`ifndef SYNTHESIS
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && is_frame) |=> (note_flags_ff == '0 && cc_flags_ff == '0 && seen_ff == '0))
      else $error("frame clear left flags set");

   a_cc_valid: assert property (@(posedge clock) disable iff (reset)
      (accept && ev.cc_wr) |=> cv_valid_ff[$past(req_first_data)]
         && cc_flags_ff[$past(req_first_data)])
      else $error("controller write not marked valid");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == mcmd_pkg::KIND_NONE) |->
         (out_chan_ff == 4'd0 && out_note_ff == 7'd0 && out_value_ff == 7'd0
          && out_ev_bend_ff == 14'd0))
      else $error("dropped transaction carries event fields");
`endif

endmodule

`default_nettype wire
